>>> design/pinned_lru_cache_manager_core_defines.svh
// ----------------------------------------------------------------------------
// pinned_lru_cache_manager_core_defines
// Shared assertion macros for the residency manager.
// ----------------------------------------------------------------------------
`ifndef PINNED_LRU_CACHE_MANAGER_CORE_DEFINES_SVH
`define PINNED_LRU_CACHE_MANAGER_CORE_DEFINES_SVH

// Whenever a holds, c holds in the same cycle.
`define PLCM_ASSERT_NOW(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("plcm check failed");

// Whenever a holds, c holds in the next cycle.
`define PLCM_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("plcm check failed");

`endif

>>> design/plcm_pkg.sv
// ----------------------------------------------------------------------------
// plcm_pkg
// Types and constants shared by the residency manager controller and datapath.
// ----------------------------------------------------------------------------
package plcm_pkg;

    localparam int IDX_W   = 5;
    localparam int BYTES_W = 28;
    localparam int MEM_W   = 34;
    localparam int CNT_W   = 6;
    localparam int IMG_W   = 6;
    localparam int LIM_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [IMG_W-1:0] MAX_IMAGES_RST = 6'd63;
    localparam logic [LIM_W-1:0] MAX_MEMORY_RST = 32'd500000000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IMAGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MEMORY = 2'd1;

    localparam logic [1:0] MODE_LOCK   = 2'd0;
    localparam logic [1:0] MODE_UNLOCK = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        KIND_HIT      = 3'd0,
        KIND_LOAD     = 3'd1,
        KIND_PINNED   = 3'd2,
        KIND_RELEASED = 3'd3,
        KIND_EVICTED  = 3'd4,
        KIND_CLEARED  = 3'd5,
        KIND_ERROR    = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_APPLY,
        CMD_EMIT,
        CMD_EVICT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    last;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic evict_needed;
        logic enforce;
    } dp_status_t;

endpackage

>>> design/plcm_ctrl.sv
// ----------------------------------------------------------------------------
// plcm_ctrl
// Request sequencer: accept, apply, emit results and walk evictions.
// ----------------------------------------------------------------------------
`include "pinned_lru_cache_manager_core_defines.svh"

module plcm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  plcm_pkg::dp_status_t  status,
    output plcm_pkg::ctl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_EMIT,
        S_EVICT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   last_now;

    assign s_tready = s_tready_reg;
    assign last_now = !(status.enforce && status.evict_needed);

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        cmd.op        = plcm_pkg::CMD_NONE;
        cmd.last      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.op        = plcm_pkg::CMD_LOAD;
                    state_next    = S_APPLY;
                    s_tready_next = 1'b0;
                end
            end
            S_APPLY: begin
                cmd.op     = plcm_pkg::CMD_APPLY;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op   = plcm_pkg::CMD_EMIT;
                    cmd.last = last_now;
                    if (last_now) begin
                        state_next    = S_IDLE;
                        s_tready_next = 1'b1;
                    end else begin
                        state_next = S_EVICT;
                    end
                end
            end
            S_EVICT: begin
                cmd.op     = plcm_pkg::CMD_EVICT;
                state_next = S_EMIT;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    `PLCM_ASSERT_NOW(a_evict_only_enforced, aclk, aresetn,
        cmd.op == plcm_pkg::CMD_EVICT, status.enforce)
    `PLCM_ASSERT_NEXT(a_accept_then_apply, aclk, aresetn,
        s_tvalid && s_tready, state_reg == S_APPLY && !s_tready)
    `PLCM_ASSERT_NOW(a_emit_has_slot, aclk, aresetn,
        cmd.op == plcm_pkg::CMD_EMIT, status.out_free)

endmodule

>>> design/plcm_datapath.sv
// ----------------------------------------------------------------------------
// plcm_datapath
// Entry tables, recency list, counters, limits and the result register.
// ----------------------------------------------------------------------------
`include "pinned_lru_cache_manager_core_defines.svh"

module plcm_datapath #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  plcm_pkg::ctl_cmd_t                    cmd,
    output plcm_pkg::dp_status_t                  status,
    input  logic [1:0]                            in_mode,
    input  logic [plcm_pkg::IDX_W-1:0]            in_index,
    input  logic [plcm_pkg::BYTES_W-1:0]          in_bytes,
    input  logic                                  cfg_we,
    input  logic [plcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [plcm_pkg::LIM_W-1:0]            cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [4:0] result_index, [10:5] images_loaded, [44:11] memory_used, [47:45] zero
    output logic [47:0]                           m_tdata,
    // [2:0] kind
    output logic [2:0]                            m_tuser,
    output logic                                  m_tlast
);

    localparam int DEPTH = (ENTRIES > 32) ? 32 : ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = plcm_pkg::IDX_W;
    localparam int CW    = plcm_pkg::CNT_W;
    localparam int GW    = plcm_pkg::IMG_W;
    localparam int MW    = plcm_pkg::MEM_W;

    // request
    logic [1:0]                   mode_reg;
    logic [IW-1:0]                idx_reg;
    logic [plcm_pkg::BYTES_W-1:0] nbytes_reg;

    // entry state
    logic [DEPTH-1:0]             resident_reg, free_reg;
    logic [COUNT_BITS-1:0]        pin_reg [DEPTH];
    logic [plcm_pkg::BYTES_W-1:0] rbytes_mem [DEPTH];
    logic [AW-1:0]                next_mem [DEPTH];
    logic [AW-1:0]                prev_mem [DEPTH];
    logic [AW-1:0]                head_reg, tail_reg;
    logic [CW-1:0]                len_reg;
    logic [plcm_pkg::IMG_W-1:0]   loaded_reg;
    logic [MW-1:0]                bytes_reg;

    logic [plcm_pkg::IMG_W-1:0]   max_img_reg;
    logic [plcm_pkg::LIM_W-1:0]   max_mem_reg;

    plcm_pkg::kind_t              kind_reg;
    logic [IW-1:0]                ridx_reg;
    logic                         enf_reg;
    logic                         link_pend_reg;
    logic [AW-1:0]                link_at_reg, link_val_reg;

    logic                         out_valid_reg;
    logic [47:0]                  out_data_reg;
    plcm_pkg::kind_t              out_kind_reg;
    logic                         out_last_reg;

    // decode of the held request
    logic [AW-1:0]         a, e, rp, rq;
    logic                  idx_ok, pin_full;
    logic [COUNT_BITS-1:0] pin_cur;
    plcm_pkg::kind_t       kind_a;
    logic                  do_clear, do_hit, do_miss, do_dec, do_push, do_rm, enf_a;
    logic                  is_apply, is_evict, rm_en, push_en;
    logic [MW-1:0]         rb_t;

    assign a        = idx_reg[AW-1:0];
    assign idx_ok   = {1'b0, idx_reg} < 6'(ENTRIES);
    assign pin_cur  = pin_reg[a];
    assign pin_full = (pin_cur == {COUNT_BITS{1'b1}});
    assign is_apply = (cmd.op == plcm_pkg::CMD_APPLY);
    assign is_evict = (cmd.op == plcm_pkg::CMD_EVICT);

    // one link read port: tail while evicting, request entry otherwise
    assign e  = is_evict ? tail_reg : a;
    assign rp = prev_mem[e];
    assign rq = next_mem[e];
    assign rb_t = MW'(rbytes_mem[tail_reg]);

    always_comb begin
        kind_a   = plcm_pkg::KIND_ERROR;
        do_clear = 1'b0;
        do_hit   = 1'b0;
        do_miss  = 1'b0;
        do_dec   = 1'b0;
        do_push  = 1'b0;
        do_rm    = 1'b0;
        enf_a    = 1'b0;
        priority if (mode_reg == plcm_pkg::MODE_CLEAR) begin
            if (CW'(len_reg) == CW'(loaded_reg)) begin
                kind_a   = plcm_pkg::KIND_CLEARED;
                do_clear = 1'b1;
            end
        end else if (mode_reg != plcm_pkg::MODE_LOCK && mode_reg != plcm_pkg::MODE_UNLOCK) begin
            kind_a = plcm_pkg::KIND_ERROR;
        end else if (!idx_ok) begin
            kind_a = plcm_pkg::KIND_ERROR;
        end else if (mode_reg == plcm_pkg::MODE_LOCK) begin
            if (!pin_full) begin
                if (resident_reg[a]) begin
                    kind_a = plcm_pkg::KIND_HIT;
                    do_hit = 1'b1;
                    do_rm  = free_reg[a];
                end else begin
                    kind_a  = plcm_pkg::KIND_LOAD;
                    do_miss = 1'b1;
                    enf_a   = 1'b1;
                end
            end
        end else begin
            if (pin_cur != '0 && resident_reg[a] && !free_reg[a]) begin
                do_dec = 1'b1;
                if (pin_cur == COUNT_BITS'(1)) begin
                    kind_a  = plcm_pkg::KIND_RELEASED;
                    do_push = 1'b1;
                    enf_a   = 1'b1;
                end else begin
                    kind_a = plcm_pkg::KIND_PINNED;
                end
            end
        end
    end

    assign rm_en   = (is_apply && do_rm) || is_evict;
    assign push_en = is_apply && do_push;

    // control and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resident_reg  <= '0;
            free_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            len_reg       <= '0;
            loaded_reg    <= '0;
            bytes_reg     <= '0;
            max_img_reg   <= plcm_pkg::MAX_IMAGES_RST;
            max_mem_reg   <= plcm_pkg::MAX_MEMORY_RST;
            enf_reg       <= 1'b0;
            link_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                pin_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == plcm_pkg::CFG_MAX_IMAGES) begin
                    max_img_reg <= cfg_data[plcm_pkg::IMG_W-1:0];
                end else if (cfg_index == plcm_pkg::CFG_MAX_MEMORY) begin
                    max_mem_reg <= cfg_data;
                end
            end
            link_pend_reg <= 1'b0;
            if (is_apply) begin
                enf_reg <= enf_a;
                if (do_clear) begin
                    resident_reg <= '0;
                    free_reg     <= '0;
                    head_reg     <= '0;
                    tail_reg     <= '0;
                    len_reg      <= '0;
                    loaded_reg   <= '0;
                    bytes_reg    <= '0;
                end
                if (do_hit || do_miss) begin
                    pin_reg[a] <= pin_cur + COUNT_BITS'(1);
                end
                if (do_dec) begin
                    pin_reg[a] <= pin_cur - COUNT_BITS'(1);
                end
                if (do_miss) begin
                    resident_reg[a] <= 1'b1;
                    loaded_reg      <= loaded_reg + GW'(1);
                    bytes_reg       <= bytes_reg + MW'(nbytes_reg);
                end
            end
            if (rm_en) begin
                if (e == head_reg) head_reg <= rq;
                if (e == tail_reg) tail_reg <= rp;
                free_reg[e] <= 1'b0;
                if (len_reg != '0) len_reg <= len_reg - CW'(1);
            end
            if (is_evict) begin
                resident_reg[tail_reg] <= 1'b0;
                if (loaded_reg != '0) loaded_reg <= loaded_reg - GW'(1);
                bytes_reg <= bytes_reg - ((bytes_reg >= rb_t) ? rb_t : bytes_reg);
            end
            if (push_en) begin
                if (len_reg == '0) begin
                    tail_reg <= a;
                end else begin
                    link_pend_reg <= 1'b1;
                end
                head_reg    <= a;
                free_reg[a] <= 1'b1;
                len_reg     <= len_reg + CW'(1);
            end
            if (cmd.op == plcm_pkg::CMD_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and link tables
    always_ff @(posedge aclk) begin
        if (cmd.op == plcm_pkg::CMD_LOAD) begin
            mode_reg   <= in_mode;
            idx_reg    <= in_index;
            nbytes_reg <= in_bytes;
        end
        if (is_apply) begin
            kind_reg <= kind_a;
            ridx_reg <= (kind_a == plcm_pkg::KIND_CLEARED ||
                         mode_reg == plcm_pkg::MODE_CLEAR ||
                         (mode_reg != plcm_pkg::MODE_LOCK &&
                          mode_reg != plcm_pkg::MODE_UNLOCK)) ? '0 : idx_reg;
            if (do_miss) rbytes_mem[a] <= nbytes_reg;
        end
        if (is_evict) begin
            kind_reg <= plcm_pkg::KIND_EVICTED;
            ridx_reg <= IW'(tail_reg);
        end
        if (rm_en) begin
            if (e != head_reg) next_mem[rp] <= rq;
            if (e != tail_reg) prev_mem[rq] <= rp;
        end
        if (push_en) begin
            if (len_reg != '0) next_mem[a] <= head_reg;
            prev_mem[a]  <= a;
            link_at_reg  <= head_reg;
            link_val_reg <= a;
        end
        // finish the push: old head points back to the new one
        if (link_pend_reg) begin
            prev_mem[link_at_reg] <= link_val_reg;
        end
        if (cmd.op == plcm_pkg::CMD_EMIT) begin
            out_data_reg <= {3'b000, bytes_reg, loaded_reg, ridx_reg};
            out_kind_reg <= kind_reg;
            out_last_reg <= cmd.last;
        end
    end

    assign status.out_free     = !out_valid_reg || m_tready;
    assign status.enforce      = enf_reg;
    assign status.evict_needed = (len_reg != '0) &&
                                 ((loaded_reg > max_img_reg) ||
                                  (bytes_reg > MW'(max_mem_reg)));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `PLCM_ASSERT_NOW(a_list_within_loaded, aclk, aresetn,
        1'b1, CW'(len_reg) <= CW'(loaded_reg))
    `PLCM_ASSERT_NOW(a_list_members_resident, aclk, aresetn,
        1'b1, (free_reg & ~resident_reg) == '0)
    `PLCM_ASSERT_NOW(a_list_count_matches, aclk, aresetn,
        1'b1, $countones(free_reg) == int'(len_reg))

endmodule

>>> design/pinned_lru_cache_manager_core.sv
// ----------------------------------------------------------------------------
// pinned_lru_cache_manager_core
// Pinned LRU residency manager: lock, unlock and clear requests in, one or
// more result beats out, with evictions from the recency tail.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | mode on s_tuser; entry_index, entry_bytes
//  m_      | out | m_tvalid/m_tready  | kind on m_tuser; result_index,
//          |     |                    | images_loaded, memory_used; last on m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request steps through accept, apply and emit, plus a list tail unlink and an
// emit for each eviction it causes; the single-port link tables set these
// steps. One request is in work at a time.
// Reset is synchronous, active low; all counts and flags clear at once.
// A stalled m_ beat holds the sequencer in its emit step; cfg_ready is high.
// ----------------------------------------------------------------------------
module pinned_lru_cache_manager_core #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] mode
    input  logic [1:0]                         s_tuser,
    // [4:0] entry_index, [32:5] entry_bytes, [39:33] zero
    input  logic [39:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] kind
    output logic [2:0]                         m_tuser,
    // [4:0] result_index, [10:5] images_loaded, [44:11] memory_used, [47:45] zero
    output logic [47:0]                        m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [plcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plcm_pkg::LIM_W-1:0]         cfg_data
);

    plcm_pkg::ctl_cmd_t   cmd;
    plcm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    plcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plcm_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_index  (s_tdata[4:0]),
        .in_bytes  (s_tdata[32:5]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> test/tb_pinned_lru_cache_manager_core.sv
// ----------------------------------------------------------------------------
// tb_pinned_lru_cache_manager_core
// Drives lock, unlock, clear and unknown-mode requests with random sender gaps
// and receiver stalls, predicts every result beat with a behavioral residency model
// and checks each beat field by field, in order, across several limit settings.
// ----------------------------------------------------------------------------
module tb_pinned_lru_cache_manager_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = 32;
    localparam int PIN_MAX     = 65535;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  index;
        logic [5:0]  images;
        logic [33:0] memory;
        logic        last;
    } result_t;

    // Residency model with its own state and limits
    class residency_scoreboard;
        bit          resident [NUM_ENTRIES];
        int unsigned pins [NUM_ENTRIES];
        bit [27:0]   footprint [NUM_ENTRIES];
        bit          on_list [NUM_ENTRIES];
        int          recency [$];  // front is most recent, back is eviction tail
        int unsigned loaded;
        bit [33:0]   used;
        bit [5:0]    image_limit;
        bit [31:0]   memory_limit;
        result_t     pending [$];
        int          mismatches;

        function new();
            image_limit  = plcm_pkg::MAX_IMAGES_RST;
            memory_limit = plcm_pkg::MAX_MEMORY_RST;
            loaded       = 0;
            used         = '0;
            mismatches   = 0;
            foreach (resident[i]) begin
                resident[i]  = 0;
                pins[i]      = 0;
                footprint[i] = '0;
                on_list[i]   = 0;
            end
        endfunction

        function void push(plcm_pkg::kind_t k, int idx);
            result_t r;
            r.kind   = k;
            r.index  = idx[4:0];
            r.images = loaded[5:0];
            r.memory = used;
            r.last   = 0;
            pending.insert(pending.size(), r);
        endfunction

        function void drop_from_list(int e);
            foreach (recency[i]) begin
                if (recency[i] == e) begin
                    recency.delete(i);
                    break;
                end
            end
            on_list[e] = 0;
        endfunction

        function void evict_over_limit();
            int t;
            while (recency.size() > 0 &&
                   (loaded > image_limit || used > {2'b0, memory_limit})) begin
                t = recency[$];
                recency.delete(recency.size() - 1);
                on_list[t]  = 0;
                resident[t] = 0;
                if (loaded > 0) loaded--;
                used = (used >= footprint[t]) ? used - footprint[t] : '0;
                push(plcm_pkg::KIND_EVICTED, t);
            end
        endfunction

        function void note_request(logic [1:0] mode, logic [4:0] idx, logic [27:0] nbytes);
            if (mode == plcm_pkg::MODE_CLEAR) begin
                if (recency.size() != loaded) begin
                    push(plcm_pkg::KIND_ERROR, 0);
                end else begin
                    foreach (on_list[e]) begin
                        if (on_list[e]) begin
                            resident[e] = 0;
                            on_list[e]  = 0;
                        end
                    end
                    recency.delete();
                    loaded = 0;
                    used   = '0;
                    push(plcm_pkg::KIND_CLEARED, 0);
                end
            end else if (mode != plcm_pkg::MODE_LOCK && mode != plcm_pkg::MODE_UNLOCK) begin
                push(plcm_pkg::KIND_ERROR, 0);
            end else if (mode == plcm_pkg::MODE_LOCK) begin
                if (pins[idx] >= PIN_MAX) begin
                    push(plcm_pkg::KIND_ERROR, idx);
                end else begin
                    pins[idx]++;
                    if (resident[idx]) begin
                        if (on_list[idx]) drop_from_list(idx);
                        push(plcm_pkg::KIND_HIT, idx);
                    end else begin
                        resident[idx]  = 1;
                        footprint[idx] = nbytes;
                        loaded++;
                        used = used + nbytes;
                        push(plcm_pkg::KIND_LOAD, idx);
                        evict_over_limit();
                    end
                end
            end else begin
                if (pins[idx] == 0 || !resident[idx] || on_list[idx]) begin
                    push(plcm_pkg::KIND_ERROR, idx);
                end else begin
                    pins[idx]--;
                    if (pins[idx] != 0) begin
                        push(plcm_pkg::KIND_PINNED, idx);
                    end else begin
                        recency.insert(0, idx);
                        on_list[idx] = 1;
                        push(plcm_pkg::KIND_RELEASED, idx);
                        evict_over_limit();
                    end
                end
            end
            pending[pending.size()-1].last = 1;
        endfunction

        function void check_beat(logic [2:0] user, logic [47:0] data, logic tlast);
            result_t want;
            result_t got;
            got = {user, data[4:0], data[10:5], data[44:11], tlast};
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d index %0d images %0d memory %0d last %0b",
                             got.kind, got.index, got.images, got.memory, got.last);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("beat mismatch: expected kind %0d index %0d images %0d memory %0d %s",
                             want.kind, want.index, want.images, want.memory,
                             $sformatf("last %0b", want.last));
                    $display("                    got kind %0d index %0d images %0d memory %0d %s",
                             got.kind, got.index, got.images, got.memory,
                             $sformatf("last %0b", got.last));
                end
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [2:0]  m_tuser;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [plcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [plcm_pkg::LIM_W-1:0]     cfg_data = '0;

    residency_scoreboard lru_model = new();
    int unsigned burst_left = 0;

    pinned_lru_cache_manager_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Receiver: stall in a pattern of its own, sometimes not at all
    int unsigned stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            lru_model.check_beat(m_tuser, m_tdata, m_tlast);
        stall_phase <= stall_phase + 1;
        if (stall_phase[8:6] == 3'd5)
            m_tready <= 1;
        else
            m_tready <= ($urandom_range(0, 3) != 0) && !(stall_phase[4:2] == 3'd6);
    end

    // Hold tvalid across a burst; drop it only for a gap
    task automatic send_request(logic [1:0] mode, logic [4:0] idx, logic [27:0] nbytes);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, nbytes, idx};
        do @(posedge aclk); while (!s_tready);
        lru_model.note_request(mode, idx, nbytes);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (lru_model.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_limits(logic [plcm_pkg::LIM_W-1:0] images,
                                logic [plcm_pkg::LIM_W-1:0] memory);
        cfg_valid <= 1;
        cfg_index <= plcm_pkg::CFG_MAX_IMAGES;
        cfg_data  <= images;
        do @(posedge aclk); while (!cfg_ready);
        lru_model.image_limit = images[5:0];
        cfg_index <= plcm_pkg::CFG_MAX_MEMORY;
        cfg_data  <= memory;
        do @(posedge aclk); while (!cfg_ready);
        lru_model.memory_limit = memory;
        cfg_valid <= 0;
    endtask

    // Mostly lock/unlock on entries 0 to span, some unknown-mode noise and clears
    task automatic random_phase(int count, int span, int max_bytes);
        int r;
        logic [4:0] idx;
        for (int i = 0; i < count; i++) begin
            r   = $urandom_range(0, 99);
            idx = 5'($urandom_range(0, span));
            if (r < 48)
                send_request(plcm_pkg::MODE_LOCK, idx, 28'($urandom_range(0, max_bytes)));
            else if (r < 90)
                send_request(plcm_pkg::MODE_UNLOCK, idx, 28'($urandom));
            else if (r < 96)
                send_request(plcm_pkg::MODE_CLEAR, 5'($urandom), 28'($urandom));
            else
                send_request(MODE_UNKNOWN, 5'($urandom), 28'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, every mode, error cases
        send_request(plcm_pkg::MODE_UNLOCK, 5'd0, 28'd0);
        send_request(plcm_pkg::MODE_LOCK, 5'd31, 28'hFFFFFFF);
        send_request(plcm_pkg::MODE_LOCK, 5'd31, 28'd0);
        send_request(plcm_pkg::MODE_CLEAR, 5'd0, 28'd0);
        send_request(plcm_pkg::MODE_UNLOCK, 5'd31, 28'd0);
        send_request(plcm_pkg::MODE_UNLOCK, 5'd31, 28'd0);
        send_request(plcm_pkg::MODE_UNLOCK, 5'd31, 28'd0);
        send_request(plcm_pkg::MODE_LOCK, 5'd0, 28'd0);
        send_request(plcm_pkg::MODE_LOCK, 5'd31, 28'd5);
        send_request(MODE_UNKNOWN, 5'd31, 28'hFFFFFFF);
        send_request(plcm_pkg::MODE_UNLOCK, 5'd0, 28'd0);
        send_request(plcm_pkg::MODE_CLEAR, 5'd31, 28'hFFFFFFF);
        send_request(plcm_pkg::MODE_CLEAR, 5'd7, 28'd1);
        drain();

        // Tight limits: released entry evicted at once
        write_limits(32'd0, 32'd0);
        send_request(plcm_pkg::MODE_LOCK, 5'd3, 28'd100);
        send_request(plcm_pkg::MODE_UNLOCK, 5'd3, 28'd0);
        drain();

        // Random phases over several limit settings
        write_limits(32'd63, 32'hFFFFFFFF);
        random_phase(80, 31, 28'hFFFFFFF);
        drain();
        write_limits(32'd4, 32'd1000);
        random_phase(90, 9, 400);
        drain();
        write_limits($urandom_range(1, 8), 32'd500000000);
        random_phase(80, 15, 200000000);
        drain();
        write_limits(32'd63, $urandom);
        random_phase(80, 31, 28'hFFFFFFF);
        drain();

        if (lru_model.mismatches == 0 && lru_model.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> pinned_lru_cache_manager_core.f
+incdir+design
design/plcm_pkg.sv
design/plcm_ctrl.sv
design/plcm_datapath.sv
design/pinned_lru_cache_manager_core.sv
test/tb_pinned_lru_cache_manager_core.sv
